### hdl/lfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_pkg
// Float32 helpers shared by the lattice fit scorer: multiply, add, rounding
// to the nearest integer, and the less-than compare, all per IEEE 754 with
// round to nearest even and gradual underflow.
// ----------------------------------------------------------------------------
package lfsa_pkg;

  localparam int STAGES = 8;

  localparam logic [2:0] REG_AB  = 3'd0;
  localparam logic [2:0] REG_CD  = 3'd1;
  localparam logic [2:0] REG_EF  = 3'd2;
  localparam logic [2:0] REG_GH  = 3'd3;
  localparam logic [2:0] REG_I   = 3'd4;
  localparam logic [2:0] REG_TOL = 3'd5;
  localparam logic [2:0] REG_LAB = 3'd6;

  localparam logic [31:0] F_QNAN = 32'h7FC0_0000;
  localparam logic signed [31:0] LABEL_NONE = -32'sd1;

  typedef struct packed {
    logic [31:0]        err;
    logic signed [31:0] label;
    logic               last;
  } side_t;

  function automatic logic [5:0] lzc48(logic [47:0] m);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // Value is m / 2^47 * 2^(e - 127); m must be nonzero.
  function automatic logic [31:0] round_pack(logic s, logic signed [11:0] e_in,
                                             logic [48:0] m_in);
    logic signed [11:0] e;
    logic [47:0]        m;
    logic [5:0]         lz;
    logic [11:0]        sh;
    logic               st;
    logic [23:0]        mant;
    logic               g;
    logic               stk;
    logic               up;
    logic [32:0]        comp;
    e = e_in;
    if (m_in[48]) begin
      m = m_in[48:1] | {47'b0, m_in[0]};
      e = e + 12'sd1;
    end else begin
      m = m_in[47:0];
    end
    lz = lzc48(m);
    m = m << lz;
    e = e - $signed({6'b0, lz});
    if (e < 12'sd1) begin
      sh = 12'(12'sd1 - e);
      if (sh > 12'd48) sh = 12'd48;
      st = |(m & ~(48'hFFFF_FFFF_FFFF << sh));
      m = (m >> sh) | {47'b0, st};
      e = 12'sd1;
    end
    mant = m[47:24];
    g = m[23];
    stk = |m[22:0];
    up = g & (stk | mant[0]);
    if (e >= 12'sd255) begin
      return {s, 8'hFF, 23'b0};
    end
    comp = {2'b0, 8'(e - 12'sd1), 23'b0} + {9'b0, mant} + {32'b0, up};
    if (comp >= 33'h0_7F80_0000) begin
      return {s, 8'hFF, 23'b0};
    end
    return {s, comp[30:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic               s;
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [23:0]        ma, mb;
    logic signed [11:0] ea, eb;
    logic [47:0]        p;
    s = a[31] ^ b[31];
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
    zero_a = (a[30:0] == 31'b0);
    zero_b = (b[30:0] == 31'b0);
    ma = {a[30:23] != 8'h00, a[22:0]};
    mb = {b[30:23] != 8'h00, b[22:0]};
    ea = (a[30:23] == 8'h00) ? 12'sd1 : $signed({4'b0, a[30:23]});
    eb = (b[30:23] == 8'h00) ? 12'sd1 : $signed({4'b0, b[30:23]});
    p = ma * mb;
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
      return F_QNAN;
    end
    if (inf_a || inf_b) begin
      return {s, 8'hFF, 23'b0};
    end
    if (zero_a || zero_b) begin
      return {s, 31'b0};
    end
    return round_pack(s, ea + eb - 12'sd126, {1'b0, p});
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [31:0]        big, sml;
    logic signed [11:0] eb, es;
    logic [11:0]        d;
    logic [47:0]        mbig, msml;
    logic               st;
    logic [48:0]        sum;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
    zero_a = (a[30:0] == 31'b0);
    zero_b = (b[30:0] == 31'b0);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = (big[30:23] == 8'h00) ? 12'sd1 : $signed({4'b0, big[30:23]});
    es = (sml[30:23] == 8'h00) ? 12'sd1 : $signed({4'b0, sml[30:23]});
    d = 12'(eb - es);
    if (d > 12'd50) d = 12'd50;
    mbig = {big[30:23] != 8'h00, big[22:0], 24'b0};
    msml = {sml[30:23] != 8'h00, sml[22:0], 24'b0};
    st = |(msml & ~(48'hFFFF_FFFF_FFFF << d));
    msml = (msml >> d) | {47'b0, st};
    if (big[31] == sml[31]) begin
      sum = {1'b0, mbig} + {1'b0, msml};
    end else begin
      sum = {1'b0, mbig - msml};
    end
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
      return F_QNAN;
    end
    if (inf_a) return a;
    if (inf_b) return b;
    if (zero_a && zero_b) return {a[31] & b[31], 31'b0};
    if (zero_a) return b;
    if (zero_b) return a;
    if (sum == 49'b0) return 32'b0;
    return round_pack(big[31], eb, sum);
  endfunction

  function automatic logic [31:0] fround(logic [31:0] h);
    logic [7:0]  e;
    logic [4:0]  sh;
    logic [23:0] mant;
    logic [24:0] ip;
    logic [23:0] rem;
    logic [23:0] half;
    e = h[30:23];
    sh = 5'(8'd150 - e);
    mant = {1'b1, h[22:0]};
    ip = {1'b0, mant >> sh};
    rem = mant & ~(24'hFF_FFFF << sh);
    half = 24'd1 << (sh - 5'd1);
    if ((rem > half) || ((rem == half) && ip[0])) ip = ip + 25'd1;
    if (e >= 8'd150) return h;
    if (e < 8'd126) return {h[31], 31'b0};
    if (ip == 25'd0) return {h[31], 31'b0};
    return round_pack(h[31], 12'sd174, {24'b0, ip});
  endfunction

  function automatic logic flt(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka, kb;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    if ((a[30:23] == 8'hFF) && (a[22:0] != 23'b0)) return 1'b0;
    if ((b[30:23] == 8'hFF) && (b[22:0] != 23'b0)) return 1'b0;
    if ((a[30:0] == 31'b0) && (b[30:0] == 31'b0)) return 1'b0;
    return ka < kb;
  endfunction

endpackage

### hdl/lattice_fit_score_assign.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_fit_score_assign
// Scores a scattering vector against one grain orientation and updates the
// vector's best error and label.
//
//   Channel   Signals                                        Direction
//   input     start, vec_x/y/z, old_error, old_label,        in
//             last_vector
//   result    busy, done, new_error, new_label,              out
//             assigned, end_of_pass
//   config    cfg_we, cfg_index, cfg_data                    in
//
// A word is accepted on every cycle with start high and busy low; busy is
// high only during reset. Each word yields one result, presented with done
// after eight register stages of float multiply, add and rounding and an
// output register. Reset clears the valid bits, done and the configuration
// registers to zero. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module lattice_fit_score_assign import lfsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        vec_x,
  input  logic [31:0]        vec_y,
  input  logic [31:0]        vec_z,
  input  logic [31:0]        old_error,
  input  logic signed [31:0] old_label,
  input  logic               last_vector,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               done,
  output logic [31:0]        new_error,
  output logic signed [31:0] new_label,
  output logic               assigned,
  output logic               end_of_pass
);

  logic [31:0] mat [9];
  logic [31:0] tol;
  logic [30:0] own;

  logic        vld  [STAGES];
  side_t       side [STAGES];
  logic [31:0] prod [9];
  logic [31:0] t3 [3];
  logic [31:0] t4 [3];
  logic [31:0] hv [3];
  logic [31:0] hr [3];
  logic [31:0] hh [3];
  logic [31:0] dv [3];
  logic [31:0] sq [3];
  logic [31:0] sxy;
  logic [31:0] sz;
  logic [31:0] score;
  logic        claim;
  logic        accept;

  assign busy   = rst;
  assign accept = start && !busy;
  assign claim  = flt(score, tol) && flt(score, side[STAGES-1].err);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) mat[i] <= 32'b0;
      tol <= 32'b0;
      own <= 31'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AB: begin
          mat[0] <= cfg_data[31:0];
          mat[1] <= cfg_data[63:32];
        end
        REG_CD: begin
          mat[2] <= cfg_data[31:0];
          mat[3] <= cfg_data[63:32];
        end
        REG_EF: begin
          mat[4] <= cfg_data[31:0];
          mat[5] <= cfg_data[63:32];
        end
        REG_GH: begin
          mat[6] <= cfg_data[31:0];
          mat[7] <= cfg_data[63:32];
        end
        REG_I:   mat[8] <= cfg_data[31:0];
        REG_TOL: tol <= cfg_data[31:0];
        REG_LAB: own <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) vld[i] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[0] <= accept;
      for (int i = 1; i < STAGES; i++) vld[i] <= vld[i-1];
      done <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= '{err: old_error, label: old_label, last: last_vector};
    for (int i = 1; i < STAGES; i++) side[i] <= side[i-1];
    for (int r = 0; r < 3; r++) begin
      prod[3*r]     <= fmul(mat[3*r], vec_x);
      prod[3*r + 1] <= fmul(mat[3*r + 1], vec_y);
      prod[3*r + 2] <= fmul(mat[3*r + 2], vec_z);
      t3[r] <= fadd(prod[3*r], prod[3*r + 1]);
      t4[r] <= prod[3*r + 2];
      hv[r] <= fadd(t3[r], t4[r]);
      hr[r] <= fround(hv[r]);
      hh[r] <= hv[r];
      dv[r] <= fadd(hh[r], hr[r] ^ 32'h8000_0000);
      sq[r] <= fmul(dv[r], dv[r]);
    end
    sxy   <= fadd(sq[0], sq[1]);
    sz    <= sq[2];
    score <= fadd(sxy, sz);
    end_of_pass <= side[STAGES-1].last;
    assigned    <= vld[STAGES-1] && claim;
    if (claim) begin
      new_error <= score;
      new_label <= $signed({1'b0, own});
    end else begin
      new_error <= side[STAGES-1].err;
      new_label <= (side[STAGES-1].label == $signed({1'b0, own})) ?
                   LABEL_NONE : side[STAGES-1].label;
    end
  end

  a_assigned_done: assert property (@(posedge clk) disable iff (rst)
    assigned |-> done) else $error("assigned without done");

  a_claim_label: assert property (@(posedge clk) disable iff (rst)
    (done && assigned) |-> (new_label == $signed({1'b0, own})))
    else $error("claimed word carries a foreign label");

  a_claim_sign: assert property (@(posedge clk) disable iff (rst)
    (done && assigned) |-> !new_error[31])
    else $error("claimed score is negative");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##9 done) else $error("result missing nine edges after acceptance");

endmodule

### dv/lattice_fit_score_assign_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_fit_score_assign_tb
// Self-checking testbench for the lattice fit scorer. A directed table covers
// reset defaults, rounding ties, signed zero, subnormals, infinities, NaNs and
// label extremes. Random words follow, mostly near-integer vectors under
// simple orientation matrices so that claims are common, with noise mixed in.
// Every result is checked against its typed table row or a float32 predictor.
// ----------------------------------------------------------------------------
module lattice_fit_score_assign_tb import lfsa_pkg::*; ();

  typedef struct {
    logic [31:0]        x, y, z, err;
    logic signed [31:0] lab;
    logic               last;
    logic               typed;
    logic [31:0]        e_err;
    logic signed [31:0] e_lab;
    logic               e_as;
  } row_t;

  typedef struct {
    logic [31:0]        err;
    logic signed [31:0] lab;
    logic               as;
    logic               eop;
  } score_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        vec_x = '0, vec_y = '0, vec_z = '0, old_error = '0;
  logic signed [31:0] old_label = '0;
  logic               last_vector = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               done;
  logic [31:0]        new_error;
  logic signed [31:0] new_label;
  logic               assigned;
  logic               end_of_pass;

  logic [31:0] orient [9];
  logic [31:0] tol_bits;
  logic [30:0] grain_label;
  score_t      pending_scores[$];
  int          errors = 0;

  lattice_fit_score_assign dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic is_nan(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  function automatic real to_real(logic [31:0] a);
    real r;
    if (a[30:23] == 0) begin
      r = real'(a[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'b0});
      return a[31] ? -r : r;
    end
    return $bitstoreal({a[31], 11'(int'(a[30:23]) - 127 + 1023), a[22:0], 29'b0});
  endfunction

  function automatic logic [31:0] to_float(real r);
    logic [63:0] b, sig, q, rem, half;
    int          e, drop;
    b = $realtobits(r);
    if (b[62:52] == 0) return {b[63], 31'b0};
    e = int'(b[62:52]) - 1023;
    sig = {11'b0, 1'b1, b[51:0]};
    drop = (e >= -126) ? 29 : 53 - (e + 150);
    if (drop > 54) return {b[63], 31'b0};
    q = sig >> drop;
    rem = sig & ((64'd1 << drop) - 1);
    half = 64'd1 << (drop - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (e < -126) return {b[63], q[30:0]};
    if (q == 64'd1 << 24) begin
      q = q >> 1;
      e = e + 1;
    end
    if (e > 127) return {b[63], 8'hFF, 23'b0};
    return {b[63], 8'(e + 127), q[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == 0) ||
        (is_inf(b) && a[30:0] == 0)) return F_QNAN;
    if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'b0};
    if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'b0};
    return to_float(to_real(a) * to_real(b));
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    real r;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
      return F_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    r = to_real(a) + to_real(b);
    if (r == 0.0) return 32'b0;
    return to_float(r);
  endfunction

  function automatic logic [31:0] nearest_int(logic [31:0] h);
    int          ex, sh;
    logic [31:0] m, ip, rem, half, mag;
    ex = int'(h[30:23]);
    if (ex >= 150) return h;
    if (ex < 126) return {h[31], 31'b0};
    sh = 150 - ex;
    m = {8'b0, 1'b1, h[22:0]};
    ip = m >> sh;
    rem = m & ((32'd1 << sh) - 1);
    half = 32'd1 << (sh - 1);
    if (rem > half || (rem == half && ip[0])) ip = ip + 1;
    if (ip == 0) return {h[31], 31'b0};
    mag = to_float(real'(ip));
    return {h[31], mag[30:0]};
  endfunction

  function automatic logic f32_less(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  function automatic score_t score_vector(row_t w);
    logic [31:0] v [3];
    logic [31:0] h, fr, s;
    score_t      o;
    v[0] = w.x;
    v[1] = w.y;
    v[2] = w.z;
    s = 32'b0;
    for (int r = 0; r < 3; r++) begin
      h = f32_add(f32_add(f32_mul(orient[3*r], v[0]), f32_mul(orient[3*r+1], v[1])),
                  f32_mul(orient[3*r+2], v[2]));
      fr = nearest_int(h);
      fr = f32_add(h, {~fr[31], fr[30:0]});
      fr = f32_mul(fr, fr);
      s = (r == 0) ? fr : f32_add(s, fr);
    end
    o.as = f32_less(s, tol_bits) && f32_less(s, w.err);
    o.err = o.as ? s : w.err;
    o.lab = o.as ? $signed({1'b0, grain_label}) :
            (w.lab == $signed({1'b0, grain_label})) ? LABEL_NONE : w.lab;
    o.eop = w.last;
    return o;
  endfunction

  task automatic drain_results();
    start <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (STAGES + 4) @(posedge clk);
  endtask

  task automatic load_grain(logic [31:0] m [9], logic [31:0] tol, logic [30:0] lab);
    logic [63:0] vals [8];
    drain_results();
    vals[0] = {m[1], m[0]};
    vals[1] = {m[3], m[2]};
    vals[2] = {m[5], m[4]};
    vals[3] = {m[7], m[6]};
    vals[4] = {32'h0, m[8]};
    vals[5] = {32'h0, tol};
    vals[6] = {33'h0, lab};
    vals[7] = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    orient = m;
    tol_bits = tol;
    grain_label = lab;
  endtask

  task automatic send_word(row_t w);
    int gap;
    logic b;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    vec_x <= w.x;
    vec_y <= w.y;
    vec_z <= w.z;
    old_error <= w.err;
    old_label <= w.lab;
    last_vector <= w.last;
    forever begin
      @(negedge clk) b = busy;
      @(posedge clk);
      if (!b) break;
    end
    if (w.typed) pending_scores.push_back('{w.e_err, w.e_lab, w.e_as, w.last});
    else pending_scores.push_back(score_vector(w));
  endtask

  always @(negedge clk) begin
    score_t e;
    if (!rst && done) begin
      if (pending_scores.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = pending_scores.pop_front();
        if (new_error !== e.err) begin
          $error("new_error expected %h actual %h", e.err, new_error);
          errors++;
        end
        if (new_label !== e.lab) begin
          $error("new_label expected %0d actual %0d", e.lab, new_label);
          errors++;
        end
        if (assigned !== e.as) begin
          $error("assigned expected %b actual %b", e.as, assigned);
          errors++;
        end
        if (end_of_pass !== e.eop) begin
          $error("end_of_pass expected %b actual %b", e.eop, end_of_pass);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] near_int_value(int span, real noise);
    real v;
    v = real'($urandom_range(0, 2 * span)) - real'(span);
    v = v + noise * (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
    return to_float(v);
  endfunction

  function automatic logic [31:0] any_float();
    case ($urandom_range(0, 5))
      0: return {1'($urandom_range(0, 1)), 8'hFF,
                 23'($urandom_range(0, 1) ? 0 : $urandom)};
      1: return {1'($urandom_range(0, 1)), 8'h00, 23'($urandom)};
      2: return {1'($urandom_range(0, 1)), 31'b0};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] entry_value();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return 32'h3F80_0000;
      2: return 32'hBF80_0000;
      3: return 32'h3F00_0000;
      4: return 32'h4000_0000;
      5: return to_float((real'($urandom_range(0, 4000)) - 2000.0) / 1000.0);
      default: return ($urandom_range(0, 3) == 0) ? any_float() : 32'h3F80_0000;
    endcase
  endfunction

  function automatic row_t random_word(int mode);
    row_t w;
    real  nz;
    nz = ($urandom_range(0, 1) == 0) ? 0.001 : 0.2;
    w.typed = 1'b0;
    w.e_err = '0;
    w.e_lab = '0;
    w.e_as = 1'b0;
    if (mode != 0 || $urandom_range(0, 3) == 0) begin
      w.x = any_float();
      w.y = any_float();
      w.z = any_float();
    end else begin
      w.x = near_int_value(20, nz);
      w.y = near_int_value(20, nz);
      w.z = near_int_value(20, nz);
    end
    case ($urandom_range(0, 4))
      0: w.err = 32'h7F80_0000;
      1: w.err = to_float(real'($urandom_range(0, 1000)) / 1000.0);
      2: w.err = 32'h3F80_0000;
      default: w.err = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0: w.lab = LABEL_NONE;
      1: w.lab = $signed({1'b0, grain_label});
      2: w.lab = $signed(32'($urandom_range(0, 9)));
      default: w.lab = $signed($urandom);
    endcase
    w.last = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  localparam logic [31:0] ONE = 32'h3F80_0000;

  row_t       table_rows [$];
  logic [31:0] m [9];
  logic [31:0] tol;
  logic [30:0] lab;

  initial begin
    for (int i = 0; i < 9; i++) orient[i] = '0;
    tol_bits = '0;
    grain_label = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset the matrix is zero, so every score is zero or NaN and never beats a zero tolerance.
    table_rows = '{
      '{32'h3F80_0000, 32'h0, 32'h0, ONE, 0, 1'b0, 1'b1, ONE, -1, 1'b0},
      '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 5, 1'b1, 1'b1, 32'h0, 5, 1'b0},
      '{32'h0, 32'h0, 32'h0, 32'h7F80_0000, -1, 1'b0, 1'b1, 32'h7F80_0000, -1, 1'b0}
    };
    foreach (table_rows[i]) send_word(table_rows[i]);

    // Identity orientation, tolerance 0.25, label 7.
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? ONE : 32'h0;
    load_grain(m, 32'h3E80_0000, 31'd7);
    table_rows = '{
      '{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, ONE, 3, 1'b0, 1'b1, 32'h0, 7, 1'b1},
      '{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h0, 7, 1'b0, 1'b1, 32'h0, -1, 1'b0},
      '{32'h3F00_0000, 32'h0, 32'h0, ONE, 3, 1'b0, 1'b1, ONE, 3, 1'b0},
      '{32'h7FC0_0001, 32'h0, 32'h0, ONE, 3, 1'b1, 1'b1, ONE, 3, 1'b0},
      '{32'hFF80_0000, 32'h0, 32'h0, ONE, 7, 1'b0, 1'b1, ONE, -1, 1'b0},
      '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1,
        32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0},
      '{32'hBE99_999A, 32'h0, 32'h0, ONE, -1, 1'b0, 1'b0, 0, 0, 1'b0},
      '{32'h0000_0001, 32'h807F_FFFF, 32'h0, ONE, 0, 1'b0, 1'b0, 0, 0, 1'b0},
      '{32'h3FC0_0000, 32'h4020_0000, 32'hC020_0000, ONE, 1, 1'b0, 1'b0, 0, 0, 1'b0},
      '{32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4B00_0001, ONE, 2, 1'b1, 1'b0, 0, 0, 1'b0},
      '{32'h3F80_0CCD, 32'h4000_0010, 32'hC040_0000, 32'h3A83_126F, 4, 1'b0, 1'b0, 0, 0,
        1'b0},
      '{32'h3F80_0CCD, 32'h4000_0010, 32'hC040_0000, 32'h0000_0001, 4, 1'b1, 1'b0, 0, 0,
        1'b0}
    };
    foreach (table_rows[i]) send_word(table_rows[i]);

    // Extreme grain: largest label, infinite tolerance, largest finite first entry, all-ones others.
    for (int i = 0; i < 9; i++) m[i] = 32'hFFFF_FFFF;
    m[0] = 32'h7F7F_FFFF;
    load_grain(m, 32'h7F80_0000, 31'h7FFF_FFFF);
    send_word('{ONE, ONE, ONE, ONE, 32'h7FFF_FFFF, 1'b1, 1'b0, 0, 0, 1'b0});
    send_word('{32'h0, 32'h0, 32'h0, ONE, 0, 1'b0, 1'b0, 0, 0, 1'b0});

    for (int phase = 0; phase < 10; phase++) begin
      for (int i = 0; i < 9; i++) m[i] = entry_value();
      case (phase % 4)
        0: tol = to_float(real'($urandom_range(1, 500)) / 1000.0);
        1: tol = 32'h7F80_0000;
        2: tol = $urandom;
        default: tol = 32'h3F80_0000;
      endcase
      lab = (phase == 9) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 9));
      load_grain(m, tol, lab);
      for (int n = 0; n < 50; n++) begin
        if (phase == 5 && n == 25) drain_results();
        send_word(random_word(($urandom_range(0, 4) == 0) ? 1 : 0));
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
hdl/lfsa_pkg.sv
hdl/lattice_fit_score_assign.sv
dv/lattice_fit_score_assign_tb.sv
